// File: hw/rtl/lprd_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed request deframer package
// Beat types, register indexes, event and error codes and reset values that
// are shared by the deframer and its users.
// ----------------------------------------------------------------------------
`default_nettype none

package lprd_pkg;

  // Field widths.
  localparam int unsigned MsgLenW  = 26;
  localparam int unsigned ArgCntW  = 18;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 26;

  // Configuration register reset values.
  localparam logic [MsgLenW-1:0] MaxMsgLenRst = 26'd33554432;
  localparam logic [ArgCntW-1:0] MaxArgCntRst = 18'd200000;

  // Every length or count header is four bytes long.
  localparam logic [MsgLenW-1:0] HdrBytes = 26'd4;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_MSG_LEN = 2'd0,
    CFG_MAX_ARG_CNT = 2'd1
  } cfg_index_e;

  // Result event kinds.
  typedef enum logic [1:0] {
    EV_ARG_BYTE  = 2'd0,
    EV_ARG_EMPTY = 2'd1,
    EV_REQ_EMPTY = 2'd2,
    EV_ERROR     = 2'd3
  } event_kind_e;

  // Error codes.
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_MSG_LONG = 3'd1,
    ERR_ARG_MANY = 3'd2,
    ERR_OVERRUN  = 3'd3,
    ERR_TRAILING = 3'd4
  } err_code_e;

  // Parser phases, one-hot.
  typedef enum logic [3:0] {
    PH_LEN    = 4'b0001,
    PH_COUNT  = 4'b0010,
    PH_ARGLEN = 4'b0100,
    PH_BYTES  = 4'b1000
  } phase_e;

  // Input beat.
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       connection_start;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic [1:0]         event_kind;
    logic [7:0]         payload_byte;
    logic [ArgCntW-1:0] argument_index;
    logic               argument_last;
    logic               frame_last;
    logic [2:0]         error_code;
  } out_beat_t;

endpackage

`default_nettype wire

// File: hw/rtl/length_prefixed_request_deframer.sv
// ----------------------------------------------------------------------------
// Length-prefixed request deframer
// Splits a byte stream of length-prefixed requests into argument byte events
// with argument index and end marks, and reports format errors once.
//
//   Channel | Direction | Handshake        | Beat
//   --------+-----------+------------------+---------------------------------
//   in      | input     | in_valid/ready   | stream byte, connection start
//   out     | output    | out_valid/ready  | event, byte, index, marks, error
//   cfg     | input     | cfg_valid/ready  | register index, write data
//
// One byte is taken per cycle while the result register is empty or being
// taken. A byte that yields a result beat sits in the input register, and the
// single parsing stage then writes its result into the result register.
// Reset clears the parser and loads the default limits.
// When the result register is full and not taken, the parsing stage holds and
// the input register fills, then in_ready_o drops. Configuration writes are
// always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_request_deframer (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire  lprd_pkg::in_beat_t              in_data_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output lprd_pkg::out_beat_t                   out_data_o,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [lprd_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  wire  [lprd_pkg::CfgDataW-1:0]         cfg_data_i
);
  import lprd_pkg::*;

  // Configuration registers.
  logic [MsgLenW-1:0] max_msg_len_q;
  logic [ArgCntW-1:0] max_arg_cnt_q;

  // Input register.
  logic     in_valid_q;
  in_beat_t in_q;

  // Parser state.
  phase_e             phase_q, phase_d;
  logic [1:0]         hdr_cnt_q, hdr_cnt_d;
  logic [23:0]        hdr_shift_q, hdr_shift_d;
  logic [MsgLenW-1:0] msg_left_q, msg_left_d;
  logic [ArgCntW-1:0] args_left_q, args_left_d;
  logic [ArgCntW-1:0] cur_arg_q, cur_arg_d;
  logic [MsgLenW-1:0] arg_left_q, arg_left_d;
  logic               err_q, err_d;

  // Result register.
  logic      out_valid_q;
  out_beat_t out_q;

  // Stage control.
  logic      advance;
  logic      res_valid;
  out_beat_t res;

  // State as seen after an optional connection start.
  phase_e             eff_phase;
  logic [1:0]         eff_hdr_cnt;
  logic [23:0]        eff_hdr_shift;
  logic [MsgLenW-1:0] eff_msg_left;
  logic [ArgCntW-1:0] eff_args_left;
  logic [ArgCntW-1:0] eff_cur_arg;
  logic [MsgLenW-1:0] eff_arg_left;
  logic               eff_err;

  // Header value and derived quantities.
  logic [31:0]        hdr_val;
  logic [MsgLenW-1:0] arg_left_dec;
  logic [ArgCntW-1:0] args_left_dec;
  logic [MsgLenW-1:0] rem;
  logic [MsgLenW-1:0] rem_less_hdr;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msg_len_q <= MaxMsgLenRst;
      max_arg_cnt_q <= MaxArgCntRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_MSG_LEN: max_msg_len_q <= cfg_data_i[MsgLenW-1:0];
        CFG_MAX_ARG_CNT: max_arg_cnt_q <= cfg_data_i[ArgCntW-1:0];
        default: ;
      endcase
    end
  end

  // Input register: refills in the cycle the parser consumes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // A connection start clears the parser before the byte is used.
  always_comb begin
    if (in_q.connection_start) begin
      eff_phase     = PH_LEN;
      eff_hdr_cnt   = '0;
      eff_hdr_shift = '0;
      eff_msg_left  = '0;
      eff_args_left = '0;
      eff_cur_arg   = '0;
      eff_arg_left  = '0;
      eff_err       = 1'b0;
    end else begin
      eff_phase     = phase_q;
      eff_hdr_cnt   = hdr_cnt_q;
      eff_hdr_shift = hdr_shift_q;
      eff_msg_left  = msg_left_q;
      eff_args_left = args_left_q;
      eff_cur_arg   = cur_arg_q;
      eff_arg_left  = arg_left_q;
      eff_err       = err_q;
    end
  end

  assign hdr_val       = {eff_hdr_shift, in_q.stream_byte};
  assign arg_left_dec  = eff_arg_left - 26'd1;
  assign args_left_dec = eff_args_left - 18'd1;
  assign rem           = eff_msg_left - hdr_val[MsgLenW-1:0];
  assign rem_less_hdr  = rem - HdrBytes;

  // Parsing step for one byte.
  always_comb begin
    phase_d     = eff_phase;
    hdr_cnt_d   = eff_hdr_cnt;
    hdr_shift_d = eff_hdr_shift;
    msg_left_d  = eff_msg_left;
    args_left_d = eff_args_left;
    cur_arg_d   = eff_cur_arg;
    arg_left_d  = eff_arg_left;
    err_d       = eff_err;

    res_valid          = 1'b0;
    res.event_kind     = EV_ARG_BYTE;
    res.payload_byte   = '0;
    res.argument_index = eff_cur_arg;
    res.argument_last  = 1'b0;
    res.frame_last     = 1'b0;
    res.error_code     = ERR_NONE;

    if (!eff_err) begin
      if (eff_phase == PH_BYTES) begin
        // Argument body byte.
        arg_left_d       = arg_left_dec;
        res_valid        = 1'b1;
        res.payload_byte = in_q.stream_byte;
        if (arg_left_dec == '0) begin
          res.argument_last = 1'b1;
          res.frame_last    = (eff_args_left == 18'd1);
          args_left_d       = args_left_dec;
          if (args_left_dec == '0) begin
            phase_d = PH_LEN;
          end else begin
            cur_arg_d = eff_cur_arg + 18'd1;
            phase_d   = PH_ARGLEN;
          end
        end
      end else if (eff_hdr_cnt != 2'd3) begin
        // Collect another header byte.
        hdr_cnt_d   = eff_hdr_cnt + 2'd1;
        hdr_shift_d = hdr_val[23:0];
      end else begin
        // Header complete.
        hdr_cnt_d   = '0;
        hdr_shift_d = '0;
        unique case (eff_phase)
          PH_LEN: begin
            if (hdr_val > {6'd0, max_msg_len_q}) begin
              res_valid      = 1'b1;
              res.error_code = ERR_MSG_LONG;
            end else if (hdr_val < 32'd4) begin
              res_valid      = 1'b1;
              res.error_code = ERR_OVERRUN;
            end else begin
              msg_left_d = hdr_val[MsgLenW-1:0] - HdrBytes;
              cur_arg_d  = '0;
              phase_d    = PH_COUNT;
            end
          end
          PH_COUNT: begin
            if (hdr_val > {14'd0, max_arg_cnt_q}) begin
              res_valid      = 1'b1;
              res.error_code = ERR_ARG_MANY;
            end else begin
              cur_arg_d = '0;
              if (hdr_val == '0) begin
                res_valid = 1'b1;
                if (eff_msg_left != '0) begin
                  res.error_code = ERR_TRAILING;
                end else begin
                  res.event_kind     = EV_REQ_EMPTY;
                  res.argument_index = '0;
                  res.frame_last     = 1'b1;
                  phase_d            = PH_LEN;
                end
              end else if (eff_msg_left < HdrBytes) begin
                res_valid      = 1'b1;
                res.error_code = ERR_OVERRUN;
              end else begin
                msg_left_d  = eff_msg_left - HdrBytes;
                args_left_d = hdr_val[ArgCntW-1:0];
                phase_d     = PH_ARGLEN;
              end
            end
          end
          PH_ARGLEN: begin
            if (hdr_val > {6'd0, eff_msg_left}) begin
              res_valid      = 1'b1;
              res.error_code = ERR_OVERRUN;
            end else if (eff_args_left == 18'd1 && rem != '0) begin
              res_valid      = 1'b1;
              res.error_code = ERR_TRAILING;
            end else if (eff_args_left != 18'd1 && rem < HdrBytes) begin
              res_valid      = 1'b1;
              res.error_code = ERR_OVERRUN;
            end else begin
              msg_left_d = (eff_args_left == 18'd1) ? rem : rem_less_hdr;
              if (hdr_val == '0) begin
                // Empty argument: report it and move on.
                res_valid         = 1'b1;
                res.event_kind    = EV_ARG_EMPTY;
                res.argument_last = 1'b1;
                res.frame_last    = (eff_args_left == 18'd1);
                args_left_d       = args_left_dec;
                if (args_left_dec == '0) begin
                  phase_d = PH_LEN;
                end else begin
                  cur_arg_d = eff_cur_arg + 18'd1;
                  phase_d   = PH_ARGLEN;
                end
              end else begin
                arg_left_d = hdr_val[MsgLenW-1:0];
                phase_d    = PH_BYTES;
              end
            end
          end
          default: ;
        endcase
        // Any error event latches until the next connection start.
        if (res_valid && res.error_code != ERR_NONE) begin
          res.event_kind = EV_ERROR;
          err_d          = 1'b1;
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEN;
      hdr_cnt_q   <= '0;
      hdr_shift_q <= '0;
      msg_left_q  <= '0;
      args_left_q <= '0;
      cur_arg_q   <= '0;
      arg_left_q  <= '0;
      err_q       <= 1'b0;
    end else if (advance) begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      hdr_shift_q <= hdr_shift_d;
      msg_left_q  <= msg_left_d;
      args_left_q <= args_left_d;
      cur_arg_q   <= cur_arg_d;
      arg_left_q  <= arg_left_d;
      err_q       <= err_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

`ifndef SYNTHESIS
  // Only error events carry an error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_kind != EV_ERROR |-> out_data_o.error_code == ERR_NONE)
    else $error("non-error event carries an error code");

  // An error event always carries a code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_kind == EV_ERROR |-> out_data_o.error_code != ERR_NONE)
    else $error("error event without an error code");

  // A latched error silences the parser until a connection start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && err_q && !in_q.connection_start |-> !res_valid)
    else $error("result produced while an error is latched");

  // The argument body phase always has bytes left to read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BYTES |-> arg_left_q != '0)
    else $error("argument body phase with no bytes left");
`endif

endmodule

`default_nettype wire
